// File: rtl/rtd_code_to_temperature_defines.svh
`ifndef RTD_CODE_TO_TEMPERATURE_DEFINES_SVH
`define RTD_CODE_TO_TEMPERATURE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RTDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RTDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rtdc_pkg.sv
`timescale 1ns / 1ps
package rtdc_pkg;

  localparam int NUM_W = 45;
  localparam int DIV_W = 18;
  localparam int ROOT_STEPS = 16;

  localparam logic [30:0] K0_DISC  = 31'd1237420918;
  localparam logic [27:0] K1_SLOPE = 28'd162551799;
  localparam logic signed [24:0] A_Q31 = 25'sd8393010;
  localparam logic signed [26:0] F_GAIN = 27'sd49870140;
  localparam logic [19:0] R_LOW  = 20'd10240;
  localparam logic [19:0] R_HIGH = 20'd102400;
  localparam logic [14:0] CODE_FULL = 15'd32767;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_CODE  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [2:0] ADDR_REF = 3'd0;
  localparam logic [2:0] ADDR_NOM = 3'd4;

  typedef struct packed {
    logic        vld;
    logic [1:0]  status;
    logic [19:0] res;
  } rtdc_meta_t;

endpackage

// File: rtl/rtdc_div_cell.sv
`timescale 1ns / 1ps
module rtdc_div_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [rtdc_pkg::DIV_W-1:0]   div_i,
  input  rtdc_pkg::rtdc_meta_t         meta_i,
  input  logic [rtdc_pkg::NUM_W-1:0]   num_i,
  input  logic [rtdc_pkg::NUM_W-1:0]   quo_i,
  input  logic [rtdc_pkg::DIV_W-1:0]   rem_i,
  output rtdc_pkg::rtdc_meta_t         meta_o,
  output logic [rtdc_pkg::NUM_W-1:0]   num_o,
  output logic [rtdc_pkg::NUM_W-1:0]   quo_o,
  output logic [rtdc_pkg::DIV_W-1:0]   rem_o
);

  logic [rtdc_pkg::DIV_W:0]   trial;
  logic                       ge;
  logic [rtdc_pkg::DIV_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_i, num_i[rtdc_pkg::NUM_W-1]};
    ge = (trial >= {1'b0, div_i});
    if (ge) begin
      rem_nxt = rtdc_pkg::DIV_W'(trial - {1'b0, div_i});
    end else begin
      rem_nxt = trial[rtdc_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_o.vld <= 1'b0;
    end else if (en) begin
      meta_o.vld <= meta_i.vld;
    end
    if (en) begin
      meta_o.status <= meta_i.status;
      meta_o.res    <= meta_i.res;
      num_o <= {num_i[rtdc_pkg::NUM_W-2:0], 1'b0};
      quo_o <= {quo_i[rtdc_pkg::NUM_W-2:0], ge};
      rem_o <= rem_nxt;
    end
  end

endmodule

// File: rtl/rtdc_root_cell.sv
`timescale 1ns / 1ps
module rtdc_root_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  rtdc_pkg::rtdc_meta_t meta_i,
  input  logic [31:0]          x_i,
  input  logic [31:0]          root_i,
  output rtdc_pkg::rtdc_meta_t meta_o,
  output logic [31:0]          x_o,
  output logic [31:0]          root_o
);

  localparam logic [31:0] BIT = 32'd1 << (30 - 2 * STEP);

  logic [31:0] trial;
  logic [31:0] x_nxt;
  logic [31:0] root_nxt;

  always_comb begin
    trial = root_i + BIT;
    if (x_i >= trial) begin
      x_nxt = x_i - trial;
      root_nxt = (root_i >> 1) + BIT;
    end else begin
      x_nxt = x_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_o.vld <= 1'b0;
    end else if (en) begin
      meta_o.vld <= meta_i.vld;
    end
    if (en) begin
      meta_o.status <= meta_i.status;
      meta_o.res    <= meta_i.res;
      x_o    <= x_nxt;
      root_o <= root_nxt;
    end
  end

endmodule

// File: rtl/rtd_code_to_temperature.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// in        in_valid / in_ready        in_raw_word[15:0]
// out       out_valid / out_ready      out_status[1:0], out_resistance[19:0],
//                                      out_temperature_f[16:0] (signed)
// cfg       psel/penable/pwrite/pready paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One transaction per cycle while in_ready is high; the path is registered in
// two front stages, a 45-cell restoring divider, one discriminant stage,
// 16 square-root cells, a multiply stage, a rounding stage and the output register.
// Synchronous active-low reset clears all valid bits and loads the default
// register values. A stalled output holds only its register; the chain keeps
// moving until the last cell holds a result, then in_ready drops.
`include "rtd_code_to_temperature_defines.svh"
module rtd_code_to_temperature (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_raw_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [19:0]        out_resistance,
  output logic signed [16:0] out_temperature_f,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NW = rtdc_pkg::NUM_W;
  localparam int DW = rtdc_pkg::DIV_W;
  localparam int RS = rtdc_pkg::ROOT_STEPS;

  // configuration
  logic [19:0] ref_res_r;
  logic [17:0] nom_res_r;
  logic [DW-1:0] r0;

  assign pready = 1'b1;
  assign r0 = (nom_res_r == '0) ? DW'(1) : nom_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_res_r <= 20'd110080;
      nom_res_r <= 18'd25600;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        nom_res_r <= pwdata[17:0];
      end else begin
        ref_res_r <= pwdata[19:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {14'd0, nom_res_r};
    end else begin
      prdata = {12'd0, ref_res_r};
    end
  end

  // flow control
  logic out_load;
  logic en;
  logic       last_vld;

  assign out_load = !out_valid || out_ready;
  assign en = out_load || !last_vld;
  assign in_ready = en;

  // stage A: code product and early status
  rtdc_pkg::rtdc_meta_t a_meta_r;
  logic [34:0] a_prod_r;
  logic [14:0] code;
  logic [1:0]  a_status;

  assign code = in_raw_word[15:1];
  always_comb begin
    if (in_raw_word[0]) begin
      a_status = rtdc_pkg::ST_FAULT;
    end else if (code == '0 || code >= rtdc_pkg::CODE_FULL) begin
      a_status = rtdc_pkg::ST_CODE;
    end else begin
      a_status = rtdc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_meta_r.vld <= 1'b0;
    end else if (en) begin
      a_meta_r.vld <= in_valid;
    end
    if (en) begin
      a_meta_r.status <= a_status;
      a_meta_r.res    <= '0;
      a_prod_r <= 35'(code) * 35'(ref_res_r);
    end
  end

  // stage B: resistance, window check, dividend
  rtdc_pkg::rtdc_meta_t b_meta_r;
  logic [NW-1:0] b_num_r;
  logic [19:0]   a_r;
  logic [1:0]    b_status;

  assign a_r = a_prod_r[34:15];
  always_comb begin
    b_status = a_meta_r.status;
    if (a_meta_r.status == rtdc_pkg::ST_OK &&
        (a_r < rtdc_pkg::R_LOW || a_r > rtdc_pkg::R_HIGH)) begin
      b_status = rtdc_pkg::ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_meta_r.vld <= 1'b0;
    end else if (en) begin
      b_meta_r.vld <= a_meta_r.vld;
    end
    if (en) begin
      b_meta_r.status <= b_status;
      b_meta_r.res    <= (a_meta_r.status == rtdc_pkg::ST_OK) ? a_r : 20'd0;
      b_num_r <= NW'(rtdc_pkg::K1_SLOPE) * NW'(a_r[16:0]);
    end
  end

  // divider chain
  rtdc_pkg::rtdc_meta_t dv_meta [NW+1];
  logic [NW-1:0] dv_num [NW+1];
  logic [NW-1:0] dv_quo [NW+1];
  logic [DW-1:0] dv_rem [NW+1];

  assign dv_meta[0] = b_meta_r;
  assign dv_num[0]  = b_num_r;
  assign dv_quo[0]  = '0;
  assign dv_rem[0]  = '0;

  for (genvar i = 0; i < NW; i++) begin : g_div
    rtdc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .div_i  (r0),
      .meta_i (dv_meta[i]),
      .num_i  (dv_num[i]),
      .quo_i  (dv_quo[i]),
      .rem_i  (dv_rem[i]),
      .meta_o (dv_meta[i+1]),
      .num_o  (dv_num[i+1]),
      .quo_o  (dv_quo[i+1]),
      .rem_o  (dv_rem[i+1])
    );
  end

  // stage C: discriminant, held at zero when negative
  rtdc_pkg::rtdc_meta_t c_meta_r;
  logic [31:0] c_disc_r;
  logic [NW-1:0] q;

  assign q = dv_quo[NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_meta_r.vld <= 1'b0;
    end else if (en) begin
      c_meta_r.vld <= dv_meta[NW].vld;
    end
    if (en) begin
      c_meta_r.status <= dv_meta[NW].status;
      c_meta_r.res    <= dv_meta[NW].res;
      if (q > NW'(rtdc_pkg::K0_DISC)) begin
        c_disc_r <= '0;
      end else begin
        c_disc_r <= {1'b0, rtdc_pkg::K0_DISC - q[30:0]};
      end
    end
  end

  // square-root chain
  rtdc_pkg::rtdc_meta_t sq_meta [RS+1];
  logic [31:0] sq_x [RS+1];
  logic [31:0] sq_root [RS+1];

  assign sq_meta[0] = c_meta_r;
  assign sq_x[0]    = c_disc_r;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < RS; j++) begin : g_root
    rtdc_root_cell #(.STEP(j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .meta_i (sq_meta[j]),
      .x_i    (sq_x[j]),
      .root_i (sq_root[j]),
      .meta_o (sq_meta[j+1]),
      .x_o    (sq_x[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  // stage E: scale to Fahrenheit
  rtdc_pkg::rtdc_meta_t e_meta_r;
  logic signed [51:0] e_prod_r;
  logic signed [24:0] n_val;

  assign n_val = rtdc_pkg::A_Q31 - $signed({1'b0, sq_root[RS][15:0], 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_meta_r.vld <= 1'b0;
    end else if (en) begin
      e_meta_r.vld <= sq_meta[RS].vld;
    end
    if (en) begin
      e_meta_r.status <= sq_meta[RS].status;
      e_meta_r.res    <= sq_meta[RS].res;
      e_prod_r <= 52'(n_val) * 52'(rtdc_pkg::F_GAIN);
    end
  end

  // stage F: offset, round half up, saturate
  rtdc_pkg::rtdc_meta_t f_meta_r;
  logic signed [16:0] f_temp_r;
  logic signed [51:0] sum;
  logic signed [19:0] t_full;
  logic signed [16:0] t_sat;

  always_comb begin
    sum = e_prod_r + 52'sd2199023255552 + 52'sd2147483648;
    t_full = 20'(sum >>> 32);
    if (t_full > 20'sd65535) begin
      t_sat = 17'sd65535;
    end else if (t_full < -20'sd65536) begin
      t_sat = -17'sd65536;
    end else begin
      t_sat = t_full[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_meta_r.vld <= 1'b0;
    end else if (en) begin
      f_meta_r.vld <= e_meta_r.vld;
    end
    if (en) begin
      f_meta_r.status <= e_meta_r.status;
      f_meta_r.res    <= e_meta_r.res;
      f_temp_r <= (e_meta_r.status == rtdc_pkg::ST_OK) ? t_sat : 17'sd0;
    end
  end

  assign last_vld = f_meta_r.vld;

  // output register
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [19:0]        out_res_r;
  logic signed [16:0] out_temp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= f_meta_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= f_meta_r.status;
      out_res_r    <= f_meta_r.res;
      out_temp_r   <= f_temp_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_resistance = out_res_r;
  assign out_temperature_f = out_temp_r;

  `RTDC_ASSERT_NOW(a_temp_zero, out_valid && out_status != rtdc_pkg::ST_OK, out_temperature_f == 17'sd0, "temperature nonzero on error status")
  `RTDC_ASSERT_NOW(a_res_zero, out_valid && (out_status == rtdc_pkg::ST_FAULT || out_status == rtdc_pkg::ST_CODE), out_resistance == 20'd0, "resistance nonzero on fault or code error")
  `RTDC_ASSERT_NOW(a_range, out_valid && out_status == rtdc_pkg::ST_RANGE, out_resistance < rtdc_pkg::R_LOW || out_resistance > rtdc_pkg::R_HIGH, "range status with in-window resistance")
  `RTDC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_temperature_f) && $stable(out_status), "stalled result changed")

endmodule

// File: bench/rtd_code_to_temperature_test.sv
`timescale 1ns / 1ps
module rtd_code_to_temperature_test;

  localparam int LATENCY = 67;
  localparam int N_RANDOM = 850;

  typedef struct {
    logic [1:0]         status;
    logic [19:0]        resistance;
    logic signed [16:0] temp_f;
  } conv_result_t;

  typedef struct {
    logic [15:0]        raw;
    bit                 known;
    logic [1:0]         status;
    logic [19:0]        resistance;
    logic signed [16:0] temp_f;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [15:0] in_raw_word = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_status;
  logic [19:0] out_resistance;
  logic signed [16:0] out_temperature_f;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [19:0] ref_ohms;
  logic [17:0] nom_ohms;
  conv_result_t expected_q[$];
  int errors = 0;

  rtd_code_to_temperature u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_raw_word(in_raw_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_resistance(out_resistance), .out_temperature_f(out_temperature_f),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] isqrt32(logic [31:0] x);
    logic [31:0] rem, root, b;
    rem = x;
    root = 0;
    for (int i = 0; i < 16; i++) begin
      b = 32'd1 << (30 - 2 * i);
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
    end
    return root[15:0];
  endfunction

  function automatic conv_result_t convert_word(logic [15:0] raw);
    conv_result_t r;
    logic [14:0] code;
    logic [63:0] res, r0, q, d;
    logic [15:0] s;
    longint n, p, t;
    code = raw[15:1];
    r = '{rtdc_pkg::ST_OK, '0, '0};
    if (raw[0]) begin
      r.status = rtdc_pkg::ST_FAULT;
      return r;
    end
    if (code == 0 || code >= rtdc_pkg::CODE_FULL) begin
      r.status = rtdc_pkg::ST_CODE;
      return r;
    end
    res = (64'(code) * 64'(ref_ohms)) >> 15;
    r.resistance = res[19:0];
    if (res < 64'(rtdc_pkg::R_LOW) || res > 64'(rtdc_pkg::R_HIGH)) begin
      r.status = rtdc_pkg::ST_RANGE;
      return r;
    end
    r0 = (nom_ohms == 0) ? 64'd1 : 64'(nom_ohms);
    q = (64'(rtdc_pkg::K1_SLOPE) * res) / r0;
    d = (q > 64'(rtdc_pkg::K0_DISC)) ? 64'd0 : 64'(rtdc_pkg::K0_DISC) - q;
    s = isqrt32(d[31:0]);
    n = longint'(rtdc_pkg::A_Q31) - 256 * longint'(s);
    p = n * longint'(rtdc_pkg::F_GAIN) + (longint'(512) << 32) + (longint'(1) << 31)
        + (longint'(1) << 52);
    t = longint'(unsigned'(p) >> 32) - (longint'(1) << 20);
    if (t > 65535) t = 65535;
    if (t < -65536) t = -65536;
    r.temp_f = t[16:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == rtdc_pkg::ADDR_REF) ref_ohms = data[19:0];
    else if (addr == rtdc_pkg::ADDR_NOM) nom_ohms = data[17:0];
  endtask

  task automatic send_word(logic [15:0] raw, bit known, conv_result_t want);
    conv_result_t pr;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pr = convert_word(raw);
    if (known && (pr.status !== want.status || pr.resistance !== want.resistance
                  || pr.temp_f !== want.temp_f))
      report_mismatch("table row", raw, pr.status);
    expected_q.push_back(pr);
    in_valid <= 1;
    in_raw_word <= raw;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // receiver with random stalls
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    conv_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_status, -1);
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_resistance !== e.resistance)
          report_mismatch("resistance", out_resistance, e.resistance);
        if (out_temperature_f !== e.temp_f)
          report_mismatch("temperature_f", out_temperature_f, e.temp_f);
      end
    end
  end

  stim_row_t table_rows[13] = '{
    '{16'h0000, 1, rtdc_pkg::ST_CODE, 20'd0, 17'sd0},
    '{16'h0001, 1, rtdc_pkg::ST_FAULT, 20'd0, 17'sd0},
    '{16'hFFFF, 1, rtdc_pkg::ST_FAULT, 20'd0, 17'sd0},
    '{16'hFFFE, 1, rtdc_pkg::ST_CODE, 20'd0, 17'sd0},
    '{16'hFFFC, 0, rtdc_pkg::ST_OK, 20'd0, 17'sd0},
    '{16'h0002, 0, rtdc_pkg::ST_OK, 20'd0, 17'sd0},
    '{16'h1E80, 0, rtdc_pkg::ST_OK, 20'd0, 17'sd0},
    '{16'h1E84, 0, rtdc_pkg::ST_OK, 20'd0, 17'sd0},
    '{16'h3000, 0, rtdc_pkg::ST_OK, 20'd0, 17'sd0},
    '{16'h5000, 0, rtdc_pkg::ST_OK, 20'd0, 17'sd0},
    '{16'h7000, 0, rtdc_pkg::ST_OK, 20'd0, 17'sd0},
    '{16'hAAAA, 0, rtdc_pkg::ST_OK, 20'd0, 17'sd0},
    '{16'h5555, 1, rtdc_pkg::ST_FAULT, 20'd0, 17'sd0}
  };

  // random codes mostly inside the valid resistance window
  function automatic logic [15:0] pick_word();
    logic [14:0] code;
    logic [63:0] lo, hi;
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return {15'($urandom), 1'b1};
      2: return {($urandom_range(0, 1) ? 15'd0 : 15'h7FFF), 1'b0};
      default: begin
        lo = (64'(rtdc_pkg::R_LOW) << 15) / ref_ohms;
        hi = ((64'(rtdc_pkg::R_HIGH) + 1) << 15) / ref_ohms;
        if (lo < 1) lo = 1;
        if (hi > 32766) hi = 32766;
        if (lo > hi) code = 15'($urandom);
        else code = 15'($urandom_range(int'(lo), int'(hi)));
        return {code, 1'b0};
      end
    endcase
  endfunction

  initial begin
    conv_result_t want;
    logic [31:0] cfg_ref[6] = '{32'd110080, 32'd256, 32'd1048575, 32'd25600,
                                32'd65536, 32'd200000};
    logic [31:0] cfg_nom[6] = '{32'd25600, 32'd262143, 32'd256, 32'd2560,
                                32'd25600, 32'd13000};
    ref_ohms = 20'd110080;
    nom_ohms = 18'd25600;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      want = '{table_rows[i].status, table_rows[i].resistance, table_rows[i].temp_f};
      send_word(table_rows[i].raw, table_rows[i].known, want);
    end
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(rtdc_pkg::ADDR_REF, cfg_ref[ph]);
      reg_write(rtdc_pkg::ADDR_NOM, cfg_nom[ph]);
      for (int k = 0; k < N_RANDOM / 6; k++) send_word(pick_word(), 0, want);
      drain();
    end
    // nominal resistance of zero, and upper register bits dropped
    reg_write(rtdc_pkg::ADDR_REF, 32'hFFF1_AE00);
    reg_write(rtdc_pkg::ADDR_NOM, 32'hFFFC_0000);
    for (int k = 0; k < 20; k++) send_word(pick_word(), 0, want);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
